>>> sv/lfds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_pkg
// Types and constants shared by the line follower drive sequencer.
// ----------------------------------------------------------------------------
package lfds_pkg;

	localparam int PAT_W   = 5;
	localparam int DIST_W  = 9;
	localparam int EL_W    = 8;
	localparam int SPD_W   = 8;
	localparam int DIR_W   = 2;
	localparam int TMR_W   = 11;
	localparam int CFG_A_W = 3;
	localparam int CFG_D_W = 11;

	typedef logic [PAT_W-1:0]   pat_t;
	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [EL_W-1:0]    elapsed_t;
	typedef logic [SPD_W-1:0]   speed_t;
	typedef logic [DIR_W-1:0]   dir_t;
	typedef logic [TMR_W-1:0]   timer_t;
	typedef logic [CFG_A_W-1:0] cfg_addr_t;
	typedef logic [CFG_D_W-1:0] cfg_data_t;
	typedef logic [1:0]         mode_t;
	typedef logic [1:0]         side_t;

	typedef struct packed {
		dir_t   right_dir;
		dir_t   left_dir;
		speed_t right_speed;
		speed_t left_speed;
	} drive_t;

	// line patterns, bit 4 is the leftmost sensor
	localparam pat_t PAT_NONE     = 5'b00000;
	localparam pat_t PAT_CENTRE   = 5'b00100;
	localparam pat_t PAT_LEFT_IN  = 5'b01000;
	localparam pat_t PAT_LEFT_IN2 = 5'b01100;
	localparam pat_t PAT_RGT_IN   = 5'b00010;
	localparam pat_t PAT_RGT_IN2  = 5'b00110;
	localparam pat_t PAT_LEFT_ED  = 5'b10000;
	localparam pat_t PAT_LEFT_ED2 = 5'b11000;
	localparam pat_t PAT_RGT_ED   = 5'b00001;
	localparam pat_t PAT_RGT_ED2  = 5'b00011;
	localparam pat_t PAT_LEFT_SH  = 5'b11100;
	localparam pat_t PAT_RGT_SH   = 5'b00111;
	localparam pat_t PAT_CROSS    = 5'b11111;

	localparam mode_t MODE_FOLLOW = 2'd0;
	localparam mode_t MODE_PIVOT  = 2'd1;
	localparam mode_t MODE_BOOST  = 2'd2;

	localparam side_t SIDE_CENTRE = 2'd0;
	localparam side_t SIDE_LEFT   = 2'd1;
	localparam side_t SIDE_RIGHT  = 2'd2;

	localparam dir_t DIR_OFF = 2'd0;
	localparam dir_t DIR_FWD = 2'd1;
	localparam dir_t DIR_REV = 2'd2;

	localparam timer_t TIMER_MAX   = 11'd2047;
	localparam speed_t BOOST_DUTY   = 8'd240;
	localparam speed_t RECOVER_DUTY = 8'd160;
	localparam speed_t DEFAULT_DUTY = 8'd80;

	// configuration register indexes
	localparam cfg_addr_t CFG_CRUISE    = 3'd0;
	localparam cfg_addr_t CFG_SLOW      = 3'd1;
	localparam cfg_addr_t CFG_PIVOT     = 3'd2;
	localparam cfg_addr_t CFG_SHARP     = 3'd3;
	localparam cfg_addr_t CFG_PIVOT_TO  = 3'd4;
	localparam cfg_addr_t CFG_SHARP_TO  = 3'd5;
	localparam cfg_addr_t CFG_BOOST_T   = 3'd6;
	localparam cfg_addr_t CFG_NEAR      = 3'd7;

	localparam speed_t RST_CRUISE   = 8'd100;
	localparam speed_t RST_SLOW     = 8'd60;
	localparam speed_t RST_PIVOT    = 8'd190;
	localparam speed_t RST_SHARP    = 8'd210;
	localparam timer_t RST_PIVOT_TO = 11'd900;
	localparam timer_t RST_SHARP_TO = 11'd1000;
	localparam timer_t RST_BOOST_T  = 11'd1500;
	localparam dist_t  RST_NEAR     = 9'd3;

endpackage

>>> sv/lfds_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_sample_if
// Request channel carrying one control sample.
// ----------------------------------------------------------------------------
interface lfds_sample_if
	import lfds_pkg::*;
	;
	logic     valid;
	logic     ready;
	pat_t     line_pattern;
	dist_t    distance_cm;
	elapsed_t elapsed_ms;

	modport source (output valid, line_pattern, distance_cm, elapsed_ms, input ready);
	modport sink (input valid, line_pattern, distance_cm, elapsed_ms, output ready);
endinterface

>>> sv/lfds_drive_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_drive_if
// Request channel carrying one motor drive command.
// ----------------------------------------------------------------------------
interface lfds_drive_if
	import lfds_pkg::*;
	;
	logic   valid;
	logic   ready;
	speed_t left_speed;
	speed_t right_speed;
	dir_t   left_dir;
	dir_t   right_dir;
	logic   halted;

	modport source (output valid, left_speed, right_speed, left_dir, right_dir, halted,
		input ready);
	modport sink (input valid, left_speed, right_speed, left_dir, right_dir, halted,
		output ready);
endinterface

>>> sv/lfds_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface lfds_cfg_if
	import lfds_pkg::*;
	;
	logic      valid;
	logic      ready;
	cfg_addr_t reg_index;
	cfg_data_t wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> sv/line_follower_drive_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_drive_sequencer_unit
// A sample taken into the sample stage is decoded into the result register,
// which feeds the drive channel. One sample per cycle while drive is ready;
// the result register frees as it drains.
// Reset: async, clears mode, timers, stop latch and drive; config registers
// return to their default values.
// ----------------------------------------------------------------------------
module line_follower_drive_sequencer_unit
	import lfds_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lfds_sample_if.sink   sample,
	lfds_drive_if.source  drive,
	lfds_cfg_if.sink      cfg
);

	// configuration
	speed_t cruise_q, slow_q, pivot_spd_q, sharp_spd_q;
	timer_t pivot_to_q, sharp_to_q, boost_t_q;
	dist_t  near_q;

	// sample stage
	logic     valid_s1;
	pat_t     pat_s1;
	dist_t    dist_s1;
	elapsed_t el_s1;

	// state
	mode_t  mode_q;
	logic   pivot_right_q, pivot_sharp_q, stop_q;
	timer_t timer_q;
	side_t  side_q;
	drive_t drv_q;

	// result register
	logic   res_valid_q;
	drive_t res_drv_q;
	logic   res_halt_q;

	logic out_free, adv, take_in;

	assign out_free = !res_valid_q || drive.ready;
	assign adv      = valid_s1 && out_free;
	assign take_in  = sample.valid && sample.ready;
	assign sample.ready = !valid_s1 || out_free;
	assign cfg.ready    = 1'b1;

	// next-state decode
	mode_t   mode_n;
	logic    pr_n, ps_n, stop_n, run_follow, leave;
	timer_t  timer_n, tmr_adv, pivot_lim;
	side_t   side_n;
	drive_t  drv_n;
	logic [TMR_W:0] tmr_sum;

	always_comb begin
		tmr_sum = {1'b0, timer_q} + {{(TMR_W+1-EL_W){1'b0}}, el_s1};
		tmr_adv = tmr_sum[TMR_W] ? TIMER_MAX : tmr_sum[TMR_W-1:0];
		pivot_lim = pivot_sharp_q ? sharp_to_q : pivot_to_q;
		mode_n  = mode_q;
		pr_n    = pivot_right_q;
		ps_n    = pivot_sharp_q;
		stop_n  = stop_q;
		timer_n = timer_q;
		side_n  = side_q;
		drv_n   = drv_q;
		run_follow = 1'b0;
		leave   = 1'b0;

		if (!stop_q) begin
			case (mode_q)
				MODE_PIVOT: begin
					timer_n = tmr_adv;
					if (pivot_right_q)
						leave = (pat_s1 == PAT_CENTRE) || (pat_s1 == PAT_RGT_IN) ||
							(pat_s1 == PAT_RGT_IN2);
					else
						leave = (pat_s1 == PAT_CENTRE) || (pat_s1 == PAT_LEFT_IN) ||
							(pat_s1 == PAT_LEFT_IN2);
					run_follow = leave || (tmr_adv >= pivot_lim);
				end
				MODE_BOOST: begin
					timer_n = tmr_adv;
					run_follow = (tmr_adv >= boost_t_q);
				end
				default: begin
					run_follow = 1'b1;
				end
			endcase
		end

		if (run_follow) begin
			mode_n = MODE_FOLLOW;
			if (dist_s1 != '0 && dist_s1 <= near_q) begin
				mode_n  = MODE_BOOST;
				timer_n = '0;
				drv_n   = '{DIR_FWD, DIR_FWD, BOOST_DUTY, BOOST_DUTY};
			end else begin
				case (pat_s1) inside
					PAT_CENTRE: begin
						drv_n  = '{DIR_FWD, DIR_FWD, cruise_q, cruise_q};
						side_n = SIDE_CENTRE;
					end
					PAT_LEFT_IN, PAT_LEFT_IN2: begin
						drv_n  = '{DIR_FWD, DIR_FWD, cruise_q, slow_q};
						side_n = SIDE_LEFT;
					end
					PAT_RGT_IN, PAT_RGT_IN2: begin
						drv_n  = '{DIR_FWD, DIR_FWD, slow_q, cruise_q};
						side_n = SIDE_RIGHT;
					end
					PAT_LEFT_ED, PAT_LEFT_ED2, PAT_LEFT_SH: begin
						mode_n  = MODE_PIVOT;
						pr_n    = 1'b0;
						ps_n    = (pat_s1 == PAT_LEFT_SH);
						timer_n = '0;
						side_n  = SIDE_LEFT;
						if (pat_s1 == PAT_LEFT_SH)
							drv_n = '{DIR_REV, DIR_FWD, sharp_spd_q, sharp_spd_q};
						else
							drv_n = '{DIR_REV, DIR_FWD, pivot_spd_q, pivot_spd_q};
					end
					PAT_RGT_ED, PAT_RGT_ED2, PAT_RGT_SH: begin
						mode_n  = MODE_PIVOT;
						pr_n    = 1'b1;
						ps_n    = (pat_s1 == PAT_RGT_SH);
						timer_n = '0;
						side_n  = SIDE_RIGHT;
						if (pat_s1 == PAT_RGT_SH)
							drv_n = '{DIR_FWD, DIR_REV, sharp_spd_q, sharp_spd_q};
						else
							drv_n = '{DIR_FWD, DIR_REV, pivot_spd_q, pivot_spd_q};
					end
					PAT_CROSS: begin
						drv_n  = '{DIR_OFF, DIR_OFF, '0, '0};
						stop_n = 1'b1;
					end
					PAT_NONE: begin
						// steer back toward the side the line was last seen on
						case (side_q)
							SIDE_LEFT:  drv_n = '{DIR_REV, DIR_FWD, RECOVER_DUTY, cruise_q};
							SIDE_RIGHT: drv_n = '{DIR_FWD, DIR_REV, cruise_q, RECOVER_DUTY};
							default:    drv_n = '{DIR_FWD, DIR_FWD, DEFAULT_DUTY, DEFAULT_DUTY};
						endcase
					end
					default: begin
						drv_n = '{DIR_FWD, DIR_FWD, DEFAULT_DUTY, DEFAULT_DUTY};
					end
				endcase
			end
		end
	end

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_q      <= RST_CRUISE;
			slow_q        <= RST_SLOW;
			pivot_spd_q   <= RST_PIVOT;
			sharp_spd_q   <= RST_SHARP;
			pivot_to_q    <= RST_PIVOT_TO;
			sharp_to_q    <= RST_SHARP_TO;
			boost_t_q     <= RST_BOOST_T;
			near_q        <= RST_NEAR;
			valid_s1      <= 1'b0;
			res_valid_q   <= 1'b0;
			mode_q        <= MODE_FOLLOW;
			pivot_right_q <= 1'b0;
			pivot_sharp_q <= 1'b0;
			stop_q        <= 1'b0;
			timer_q       <= '0;
			side_q        <= SIDE_CENTRE;
			drv_q         <= '{DIR_OFF, DIR_OFF, '0, '0};
		end else begin
			if (cfg.valid) begin
				unique case (cfg.reg_index)
					CFG_CRUISE:   cruise_q    <= cfg.wdata[SPD_W-1:0];
					CFG_SLOW:     slow_q      <= cfg.wdata[SPD_W-1:0];
					CFG_PIVOT:    pivot_spd_q <= cfg.wdata[SPD_W-1:0];
					CFG_SHARP:    sharp_spd_q <= cfg.wdata[SPD_W-1:0];
					CFG_PIVOT_TO: pivot_to_q  <= cfg.wdata[TMR_W-1:0];
					CFG_SHARP_TO: sharp_to_q  <= cfg.wdata[TMR_W-1:0];
					CFG_BOOST_T:  boost_t_q   <= cfg.wdata[TMR_W-1:0];
					CFG_NEAR:     near_q      <= cfg.wdata[DIST_W-1:0];
					default:      ;
				endcase
			end
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (out_free)
				res_valid_q <= valid_s1;
			if (adv) begin
				mode_q        <= mode_n;
				pivot_right_q <= pr_n;
				pivot_sharp_q <= ps_n;
				stop_q        <= stop_n;
				timer_q       <= timer_n;
				side_q        <= side_n;
				drv_q         <= drv_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			pat_s1  <= sample.line_pattern;
			dist_s1 <= sample.distance_cm;
			el_s1   <= sample.elapsed_ms;
		end
		if (adv) begin
			res_drv_q  <= drv_n;
			res_halt_q <= stop_n;
		end
	end

	assign drive.valid       = res_valid_q;
	assign drive.left_speed  = res_drv_q.left_speed;
	assign drive.right_speed = res_drv_q.right_speed;
	assign drive.left_dir    = res_drv_q.left_dir;
	assign drive.right_dir   = res_drv_q.right_dir;
	assign drive.halted      = res_halt_q;

endmodule

>>> tb/line_follower_drive_sequencer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_drive_sequencer_unit_test
// Drives control samples into the drive sequencer and checks each drive
// command against an in-bench model of the follow, pivot, boost and stop
// behavior. A short table of hand-picked samples runs first at the default
// settings. Random phases follow at the defaults, the low extreme, the high
// extreme and random register values. Both channels idle at random. The run
// ends by latching the stop and checking that it holds.
// ----------------------------------------------------------------------------
module line_follower_drive_sequencer_unit_test;
	import lfds_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int          PHASE_ITEMS = 80;

	typedef struct packed {
		drive_t drv;
		logic   halt;
	} cmd_t;

	// model state of the sequencer
	typedef struct {
		mode_t       mode;
		bit          turn_right;
		bit          turn_sharp;
		int unsigned tmr;
		side_t       side;
		bit          stopped;
		drive_t      drv;
	} nav_t;

	typedef struct {
		pat_t     pat;
		dist_t    range_cm;
		elapsed_t el;
		bit       typed;
		drive_t   want;
	} route_row_t;

	typedef enum {CFG_LOW, CFG_HIGH, CFG_ANY} cfg_style_t;

	logic clk = 1'b0;
	logic arst_n;

	lfds_sample_if sample_ch ();
	lfds_drive_if  drive_ch ();
	lfds_cfg_if    cfg_ch ();

	line_follower_drive_sequencer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.drive  (drive_ch),
		.cfg    (cfg_ch)
	);

	cfg_data_t   setting [8];
	nav_t        nav;
	cmd_t        pending [$];
	route_row_t  route [25];
	bit          steady;
	int unsigned mismatches;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;

	pat_t known_pats [13] = '{PAT_NONE, PAT_CENTRE, PAT_LEFT_IN, PAT_LEFT_IN2, PAT_RGT_IN,
		PAT_RGT_IN2, PAT_LEFT_ED, PAT_LEFT_ED2, PAT_RGT_ED, PAT_RGT_ED2, PAT_LEFT_SH,
		PAT_RGT_SH, PAT_CROSS};
	cfg_addr_t reg_order [8] = '{CFG_CRUISE, CFG_SLOW, CFG_PIVOT, CFG_SHARP, CFG_PIVOT_TO,
		CFG_SHARP_TO, CFG_BOOST_T, CFG_NEAR};

	always #2 clk = ~clk;

	function automatic drive_t mk_drive(speed_t ls, speed_t rs, dir_t ld, dir_t rd);
		drive_t d;
		d.left_speed  = ls;
		d.right_speed = rs;
		d.left_dir    = ld;
		d.right_dir   = rd;
		return d;
	endfunction

	function automatic nav_t begin_turn(nav_t s, bit right, bit sharp);
		speed_t duty = sharp ? setting[CFG_SHARP][SPD_W-1:0] : setting[CFG_PIVOT][SPD_W-1:0];
		s.mode       = MODE_PIVOT;
		s.turn_right = right;
		s.turn_sharp = sharp;
		s.tmr        = 0;
		s.side       = right ? SIDE_RIGHT : SIDE_LEFT;
		s.drv        = right ? mk_drive(duty, duty, DIR_REV, DIR_FWD)
		                     : mk_drive(duty, duty, DIR_FWD, DIR_REV);
		return s;
	endfunction

	// next state after one sample; drv and stopped give the command
	function automatic nav_t next_nav(nav_t s, pat_t p, dist_t d, elapsed_t e);
		speed_t cruise = setting[CFG_CRUISE][SPD_W-1:0];
		speed_t slow   = setting[CFG_SLOW][SPD_W-1:0];
		bit     decode;
		if (s.stopped)
			return s;
		if (s.mode == MODE_PIVOT || s.mode == MODE_BOOST)
			s.tmr = (s.tmr + e > TIMER_MAX) ? TIMER_MAX : s.tmr + e;
		case (s.mode)
			MODE_PIVOT: begin
				if (s.turn_right)
					decode = (p == PAT_CENTRE || p == PAT_RGT_IN || p == PAT_RGT_IN2);
				else
					decode = (p == PAT_CENTRE || p == PAT_LEFT_IN || p == PAT_LEFT_IN2);
				if (s.tmr >= (s.turn_sharp ? setting[CFG_SHARP_TO] : setting[CFG_PIVOT_TO]))
					decode = 1'b1;
			end
			MODE_BOOST: decode = (s.tmr >= setting[CFG_BOOST_T]);
			default:    decode = 1'b1;
		endcase
		if (!decode)
			return s;
		s.mode = MODE_FOLLOW;
		if (d != 0 && d <= setting[CFG_NEAR]) begin
			s.mode = MODE_BOOST;
			s.tmr  = 0;
			s.drv  = mk_drive(BOOST_DUTY, BOOST_DUTY, DIR_FWD, DIR_FWD);
			return s;
		end
		case (p)
			PAT_CENTRE: begin
				s.drv  = mk_drive(cruise, cruise, DIR_FWD, DIR_FWD);
				s.side = SIDE_CENTRE;
			end
			PAT_LEFT_IN, PAT_LEFT_IN2: begin
				s.drv  = mk_drive(slow, cruise, DIR_FWD, DIR_FWD);
				s.side = SIDE_LEFT;
			end
			PAT_RGT_IN, PAT_RGT_IN2: begin
				s.drv  = mk_drive(cruise, slow, DIR_FWD, DIR_FWD);
				s.side = SIDE_RIGHT;
			end
			PAT_LEFT_ED, PAT_LEFT_ED2: s = begin_turn(s, 1'b0, 1'b0);
			PAT_RGT_ED, PAT_RGT_ED2:   s = begin_turn(s, 1'b1, 1'b0);
			PAT_LEFT_SH:               s = begin_turn(s, 1'b0, 1'b1);
			PAT_RGT_SH:                s = begin_turn(s, 1'b1, 1'b1);
			PAT_CROSS: begin
				s.drv     = mk_drive('0, '0, DIR_OFF, DIR_OFF);
				s.stopped = 1'b1;
			end
			PAT_NONE: begin
				case (s.side)
					SIDE_LEFT:  s.drv = mk_drive(cruise, RECOVER_DUTY, DIR_FWD, DIR_REV);
					SIDE_RIGHT: s.drv = mk_drive(RECOVER_DUTY, cruise, DIR_REV, DIR_FWD);
					default:    s.drv = mk_drive(DEFAULT_DUTY, DEFAULT_DUTY, DIR_FWD, DIR_FWD);
				endcase
			end
			default: s.drv = mk_drive(DEFAULT_DUTY, DEFAULT_DUTY, DIR_FWD, DIR_FWD);
		endcase
		return s;
	endfunction

	// mostly short pauses, now and then a long one
	function automatic int unsigned pause_len();
		return ($urandom_range(0, 6) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic cfg_data_t pick_value(cfg_addr_t idx, cfg_style_t style);
		int unsigned top;
		case (idx)
			CFG_CRUISE, CFG_SLOW, CFG_PIVOT, CFG_SHARP: top = 255;
			CFG_NEAR: top = 510;
			default:  top = TIMER_MAX;
		endcase
		case (style)
			CFG_LOW:  return '0;
			CFG_HIGH: return cfg_data_t'(top);
			default:  return ($urandom_range(0, 2) == 0) ? cfg_data_t'($urandom_range(0, top))
			                                             : cfg_data_t'($urandom_range(0, top / 5));
		endcase
	endfunction

	task automatic send_sample(input pat_t p, input dist_t d, input elapsed_t e,
		input bit typed = 1'b0, input drive_t want = '0);
		sample_ch.valid        <= 1'b1;
		sample_ch.line_pattern <= p;
		sample_ch.distance_cm  <= d;
		sample_ch.elapsed_ms   <= e;
		do @(posedge clk); while (!sample_ch.ready);
		nav = next_nav(nav, p, d, e);
		pending.push_back(typed ? cmd_t'{want, 1'b0} : cmd_t'{nav.drv, nav.stopped});
		if (!steady && $urandom_range(0, 2) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat (pause_len()) @(posedge clk);
		end
	endtask

	// hold off the sender until every command is back
	task automatic settle(input int unsigned extra);
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_all(input cfg_style_t style);
		cfg_data_t val;
		foreach (reg_order[k]) begin
			val = pick_value(reg_order[k], style);
			cfg_ch.valid     <= 1'b1;
			cfg_ch.reg_index <= reg_order[k];
			cfg_ch.wdata     <= val;
			do @(posedge clk); while (!cfg_ch.ready);
			setting[reg_order[k]] = val;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			drive_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			drive_ch.ready <= 1'b0;
			stall_left     <= stall_left - 1;
		end else begin
			drive_ch.ready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left <= pause_len();
		end
	end

	always @(posedge clk) begin
		cmd_t want;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (pending.size() == 0) begin
				$error("drive command with no sample pending");
				mismatches++;
			end else begin
				want = pending.pop_front();
				if (drive_ch.left_speed !== want.drv.left_speed) begin
					$error("left_speed: expected %0d, got %0d", want.drv.left_speed,
						drive_ch.left_speed);
					mismatches++;
				end
				if (drive_ch.right_speed !== want.drv.right_speed) begin
					$error("right_speed: expected %0d, got %0d", want.drv.right_speed,
						drive_ch.right_speed);
					mismatches++;
				end
				if (drive_ch.left_dir !== want.drv.left_dir) begin
					$error("left_dir: expected %0d, got %0d", want.drv.left_dir,
						drive_ch.left_dir);
					mismatches++;
				end
				if (drive_ch.right_dir !== want.drv.right_dir) begin
					$error("right_dir: expected %0d, got %0d", want.drv.right_dir,
						drive_ch.right_dir);
					mismatches++;
				end
				if (drive_ch.halted !== want.halt) begin
					$error("halted: expected %0d, got %0d", want.halt, drive_ch.halted);
					mismatches++;
				end
			end
		end
	end

	initial begin
		pat_t     p;
		dist_t    d;
		elapsed_t e;
		int       dist_hi;
		nav_t     probe;

		arst_n                 <= 1'b0;
		sample_ch.valid        <= 1'b0;
		sample_ch.line_pattern <= '0;
		sample_ch.distance_cm  <= '0;
		sample_ch.elapsed_ms   <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.reg_index       <= CFG_CRUISE;
		cfg_ch.wdata           <= '0;
		steady      = 1'b0;
		mismatches  = 0;

		setting[CFG_CRUISE]   = cfg_data_t'(RST_CRUISE);
		setting[CFG_SLOW]     = cfg_data_t'(RST_SLOW);
		setting[CFG_PIVOT]    = cfg_data_t'(RST_PIVOT);
		setting[CFG_SHARP]    = cfg_data_t'(RST_SHARP);
		setting[CFG_PIVOT_TO] = RST_PIVOT_TO;
		setting[CFG_SHARP_TO] = RST_SHARP_TO;
		setting[CFG_BOOST_T]  = RST_BOOST_T;
		setting[CFG_NEAR]     = cfg_data_t'(RST_NEAR);
		nav = '{MODE_FOLLOW, 1'b0, 1'b0, 0, SIDE_CENTRE, 1'b0, drive_t'('0)};

		// default settings: cruise 100, slow 60, pivot 190, sharp 210,
		// timeouts 900/1000, boost 1500, near 3
		route = '{
			'{PAT_CENTRE,   9'd0,   8'd0,   1'b1,
				mk_drive(RST_CRUISE, RST_CRUISE, DIR_FWD, DIR_FWD)},
			'{PAT_NONE,     9'd510, 8'd0,   1'b1,
				mk_drive(DEFAULT_DUTY, DEFAULT_DUTY, DIR_FWD, DIR_FWD)},
			'{PAT_LEFT_IN,  9'd4,   8'd0,   1'b1,
				mk_drive(RST_SLOW, RST_CRUISE, DIR_FWD, DIR_FWD)},
			'{PAT_NONE,     9'd0,   8'd0,   1'b1,
				mk_drive(RST_CRUISE, RECOVER_DUTY, DIR_FWD, DIR_REV)},
			'{PAT_RGT_IN2,  9'd0,   8'd0,   1'b1,
				mk_drive(RST_CRUISE, RST_SLOW, DIR_FWD, DIR_FWD)},
			'{PAT_NONE,     9'd0,   8'd0,   1'b1,
				mk_drive(RECOVER_DUTY, RST_CRUISE, DIR_REV, DIR_FWD)},
			'{PAT_LEFT_IN2, 9'd0,   8'd0,   1'b0, '0},
			'{PAT_RGT_IN,   9'd0,   8'd0,   1'b0, '0},
			'{5'b01010,     9'd0,   8'd0,   1'b1,
				mk_drive(DEFAULT_DUTY, DEFAULT_DUTY, DIR_FWD, DIR_FWD)},
			'{PAT_LEFT_ED,  9'd0,   8'd0,   1'b1,
				mk_drive(RST_PIVOT, RST_PIVOT, DIR_FWD, DIR_REV)},
			// cross and the wrong inner pattern do not end a left pivot
			'{PAT_CROSS,    9'd0,   8'd100, 1'b0, '0},
			'{PAT_RGT_IN,   9'd0,   8'd100, 1'b0, '0},
			'{PAT_LEFT_IN2, 9'd0,   8'd5,   1'b0, '0},
			'{PAT_RGT_ED2,  9'd0,   8'd0,   1'b1,
				mk_drive(RST_PIVOT, RST_PIVOT, DIR_REV, DIR_FWD)},
			// right pivot runs into its timeout on the fourth sample
			'{PAT_NONE,     9'd0,   8'd255, 1'b0, '0},
			'{PAT_NONE,     9'd0,   8'd255, 1'b0, '0},
			'{PAT_NONE,     9'd0,   8'd255, 1'b0, '0},
			'{PAT_NONE,     9'd0,   8'd255, 1'b0, '0},
			'{PAT_RGT_SH,   9'd0,   8'd0,   1'b1,
				mk_drive(RST_SHARP, RST_SHARP, DIR_REV, DIR_FWD)},
			'{PAT_RGT_IN2,  9'd0,   8'd1,   1'b0, '0},
			'{PAT_LEFT_ED2, 9'd0,   8'd0,   1'b0, '0},
			'{PAT_CENTRE,   9'd0,   8'd0,   1'b0, '0},
			'{PAT_LEFT_SH,  9'd0,   8'd0,   1'b1,
				mk_drive(RST_SHARP, RST_SHARP, DIR_FWD, DIR_REV)},
			// exit pattern with an obstacle at the limit goes straight to boost
			'{PAT_CENTRE,   9'd3,   8'd10,  1'b1,
				mk_drive(BOOST_DUTY, BOOST_DUTY, DIR_FWD, DIR_FWD)},
			'{PAT_RGT_ED,   9'd0,   8'd255, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (route[i])
			send_sample(route[i].pat, route[i].range_cm, route[i].el, route[i].typed,
				route[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0) begin
				settle(4);
				write_all(ph == 1 ? CFG_LOW : ph == 2 ? CFG_HIGH : CFG_ANY);
			end
			steady = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0)
					p = pat_t'($urandom_range(0, 31));
				else
					p = known_pats[$urandom_range(0, 12)];
				dist_hi = (setting[CFG_NEAR] > 508) ? 510 : setting[CFG_NEAR] + 2;
				case ($urandom_range(0, 11))
					0, 1, 2, 3: d = '0;
					4:          d = dist_t'($urandom_range(1, dist_hi));
					default:    d = dist_t'($urandom_range(0, 510));
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: e = elapsed_t'($urandom_range(0, 40));
					9:                e = 8'd255;
					default:          e = elapsed_t'($urandom_range(0, 255));
				endcase
				// keep the stop for the end: drop the rightmost sensor instead
				probe = next_nav(nav, p, d, e);
				if (probe.stopped)
					p = PAT_CROSS ^ PAT_RGT_ED;
				send_sample(p, d, e);
				if ($urandom_range(0, 59) == 0)
					settle(0);
			end
		end

		// latch the stop, then everything must be ignored
		steady = 1'b0;
		while (!nav.stopped)
			send_sample(PAT_CROSS, '0, 8'd255);
		repeat (8)
			send_sample(pat_t'($urandom_range(0, 31)), dist_t'($urandom_range(0, 510)),
				elapsed_t'($urandom_range(0, 255)));

		settle(8);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
